@@ rtl/sgb_pkg.sv @@
// Shared types, constants and helper functions of the separable Gaussian blur.
package sgb_pkg;

  localparam int MAX_RADIUS = 7;
  localparam int TAPS       = 2 * MAX_RADIUS + 1;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int BANK_W     = $clog2(TAPS);
  localparam int DIM_W      = 11;
  localparam int RAD_W      = 3;
  localparam int WEIGHT_W   = 16;
  localparam int FRAC_W     = 15;
  localparam int CHAN_W     = 8;
  localparam int CHANNELS   = 3;
  localparam int PIX_W      = CHANNELS * CHAN_W;
  localparam int PROD_W     = WEIGHT_W + CHAN_W;
  localparam int SUM_W      = PROD_W + 4;
  localparam int GROUP      = 4;
  localparam int GROUPS     = (TAPS + GROUP - 1) / GROUP;
  localparam int PEND_W     = 14;
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_RADIUS       = 3'd2,
    REG_WEIGHTS_LOW  = 3'd3,
    REG_WEIGHTS_HIGH = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef logic [CHAN_W-1:0] chan_t;

  // red in the low byte
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  // one horizontal step: window update plus an optional row store write
  typedef struct packed {
    logic              step;
    logic              fill;
    logic              repeat_px;
    pixel_t            px;
    logic              wr;
    logic [BANK_W-1:0] bank;
    logic [COL_W-1:0]  col;
  } hop_t;

  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] bank;
    logic [COL_W-1:0]  col;
    pixel_t            data;
  } row_wr_t;

  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [BANK_W-1:0] bank;
    logic              frame_end;
  } emit_req_t;

  typedef struct packed {
    pixel_t px;
    logic   frame_end;
  } result_t;

  function automatic logic [WEIGHT_W-1:0] weight_at(input logic [CFG_W-1:0] wl,
                                                    input logic [CFG_W-1:0] wh,
                                                    input logic [RAD_W-1:0] d);
    logic [2*CFG_W-1:0] all_w;
    all_w = {wh, wl};
    return all_w[{d, 4'b0000} +: WEIGHT_W];
  endfunction

  function automatic chan_t round_sat(input logic [SUM_W-1:0] acc);
    logic [SUM_W-1:0] t;
    t = acc + SUM_W'(1 << (FRAC_W - 1));
    if (t[SUM_W-1:FRAC_W+CHAN_W] != '0) return '1;
    return t[FRAC_W +: CHAN_W];
  endfunction

  function automatic logic [BANK_W-1:0] bank_add(input logic [BANK_W-1:0] a,
                                                 input logic [BANK_W-1:0] b);
    logic [BANK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (BANK_W+1)'(TAPS)) s = s - (BANK_W+1)'(TAPS);
    return s[BANK_W-1:0];
  endfunction

endpackage

@@ rtl/sgb_row_ram.sv @@
// Simple dual-port RAM: one write port, one registered read port.
module sgb_row_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/sgb_hfilter.sv @@
// Horizontal pass: pixel window, one multiplier lane per tap, adder tree, rounding.
module sgb_hfilter import sgb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [RAD_W-1:0] radius,
  input  logic [CFG_W-1:0] weights_low,
  input  logic [CFG_W-1:0] weights_high,
  input  hop_t             hop,
  output row_wr_t          row_wr
);

  pixel_t              window [TAPS];
  logic [WEIGHT_W-1:0] lane_wt [TAPS];
  logic                lane_en [TAPS];
  logic [PROD_W-1:0]   prod [CHANNELS][TAPS];
  logic [SUM_W-1:0]    part [CHANNELS][GROUPS];
  logic [SUM_W-1:0]    part_next [CHANNELS][GROUPS];
  logic [SUM_W-1:0]    total [CHANNELS];

  logic              m1_valid, m2_valid, m3_valid;
  logic [BANK_W-1:0] m1_bank, m2_bank, m3_bank;
  logic [COL_W-1:0]  m1_col, m2_col, m3_col;

  // tap k sits |k - radius| away from the center
  always_comb begin
    logic [4:0] kk;
    logic [4:0] rr;
    logic [4:0] dd;
    for (int k = 0; k < TAPS; k++) begin
      kk = 5'(k);
      rr = {2'b00, radius};
      dd = (kk > rr) ? kk - rr : rr - kk;
      lane_en[k] = kk <= {rr[3:0], 1'b0};
      lane_wt[k] = weight_at(weights_low, weights_high, dd[RAD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (hop.step) begin
      if (hop.fill) begin
        for (int k = 0; k < TAPS; k++) window[k] <= hop.px;
      end else begin
        window[0] <= hop.repeat_px ? window[0] : hop.px;
        for (int k = 1; k < TAPS; k++) window[k] <= window[k-1];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      for (int g = 0; g < GROUPS; g++) begin
        part_next[c][g] = '0;
        for (int l = 0; l < GROUP; l++) begin
          if (g * GROUP + l < TAPS) part_next[c][g] = part_next[c][g] + SUM_W'(prod[c][g*GROUP+l]);
        end
      end
    end
    for (int c = 0; c < CHANNELS; c++) begin
      total[c] = '0;
      for (int g = 0; g < GROUPS; g++) total[c] = total[c] + part[c][g];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < TAPS; k++) begin
        prod[c][k] <= lane_en[k] ? lane_wt[k] * window[k][c*CHAN_W +: CHAN_W] : '0;
      end
      for (int g = 0; g < GROUPS; g++) part[c][g] <= part_next[c][g];
    end
    m1_bank <= hop.bank;
    m1_col  <= hop.col;
    m2_bank <= m1_bank;
    m2_col  <= m1_col;
    m3_bank <= m2_bank;
    m3_col  <= m2_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
    end else begin
      m1_valid <= hop.step && hop.wr;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
    end
  end

  always_comb begin
    row_wr.valid      = m3_valid;
    row_wr.bank       = m3_bank;
    row_wr.col        = m3_col;
    row_wr.data.red   = round_sat(total[0]);
    row_wr.data.green = round_sat(total[1]);
    row_wr.data.blue  = round_sat(total[2]);
  end

endmodule

@@ rtl/sgb_vfilter.sv @@
// Vertical pass: row store banks, lane row select, multiplier lanes, adder tree.
module sgb_vfilter import sgb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [RAD_W-1:0] radius,
  input  logic [DIM_W-1:0] height,
  input  logic [CFG_W-1:0] weights_low,
  input  logic [CFG_W-1:0] weights_high,
  input  row_wr_t          row_wr,
  input  emit_req_t        req,
  output logic             res_valid,
  output result_t          res
);

  logic [PIX_W-1:0]    rdata [TAPS];
  logic [WEIGHT_W-1:0] lane_wt [TAPS];
  logic                lane_en [TAPS];
  logic [BANK_W-1:0]   bank_next [TAPS];

  emit_req_t         s1;
  logic              s2_valid, s3_valid, s4_valid, s5_valid, s6_valid, s7_valid, s8_valid;
  logic              s2_fe, s3_fe, s4_fe, s5_fe, s6_fe, s7_fe, s8_fe;
  logic [COL_W-1:0]  s2_col, s3_col, s4_col;
  logic [BANK_W-1:0] s2_bank [TAPS];
  logic [BANK_W-1:0] s3_bank [TAPS];
  logic [BANK_W-1:0] s4_bank [TAPS];
  logic [BANK_W-1:0] s5_bank [TAPS];
  pixel_t            s6_px [TAPS];
  logic [PROD_W-1:0] prod [CHANNELS][TAPS];
  logic [SUM_W-1:0]  part [CHANNELS][GROUPS];
  logic [SUM_W-1:0]  part_next [CHANNELS][GROUPS];
  logic [SUM_W-1:0]  total [CHANNELS];

  // lane i covers row offset i - MAX_RADIUS
  always_comb begin
    logic [3:0] dd;
    for (int i = 0; i < TAPS; i++) begin
      dd = (i >= MAX_RADIUS) ? 4'(i - MAX_RADIUS) : 4'(MAX_RADIUS - i);
      lane_en[i] = dd <= {1'b0, radius};
      lane_wt[i] = weight_at(weights_low, weights_high, dd[RAD_W-1:0]);
    end
  end

  // clamp each lane's row to the frame, then map it to its bank
  always_comb begin
    logic signed [ROW_W+1:0] q;
    logic signed [ROW_W+1:0] hmax;
    logic signed [ROW_W+1:0] delta;
    logic [BANK_W:0]         dm;
    hmax = signed'((ROW_W+2)'(height)) - 1;
    for (int i = 0; i < TAPS; i++) begin
      q = signed'({2'b00, s1.row}) + signed'((ROW_W+2)'(i)) - signed'((ROW_W+2)'(MAX_RADIUS));
      if (q < 0) q = '0;
      else if (q > hmax) q = hmax;
      delta = q - signed'({2'b00, s1.row});
      dm = (delta < 0) ? (BANK_W+1)'(delta + signed'((ROW_W+2)'(TAPS))) : (BANK_W+1)'(delta);
      bank_next[i] = bank_add(s1.bank, dm[BANK_W-1:0]);
    end
  end

  for (genvar j = 0; j < TAPS; j++) begin : g_bank
    sgb_row_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_ram (
      .clk    (clk),
      .wr_en  (row_wr.valid && row_wr.bank == BANK_W'(j)),
      .wr_addr(row_wr.col),
      .wr_data(row_wr.data),
      .rd_addr(s4_col),
      .rd_data(rdata[j])
    );
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      for (int g = 0; g < GROUPS; g++) begin
        part_next[c][g] = '0;
        for (int l = 0; l < GROUP; l++) begin
          if (g * GROUP + l < TAPS) part_next[c][g] = part_next[c][g] + SUM_W'(prod[c][g*GROUP+l]);
        end
      end
    end
    for (int c = 0; c < CHANNELS; c++) begin
      total[c] = '0;
      for (int g = 0; g < GROUPS; g++) total[c] = total[c] + part[c][g];
    end
  end

  always_ff @(posedge clk) begin
    s1.col       <= req.col;
    s1.row       <= req.row;
    s1.bank      <= req.bank;
    s1.frame_end <= req.frame_end;
    s2_col <= s1.col;
    s3_col <= s2_col;
    s4_col <= s3_col;
    s2_fe  <= s1.frame_end;
    s3_fe  <= s2_fe;
    s4_fe  <= s3_fe;
    s5_fe  <= s4_fe;
    s6_fe  <= s5_fe;
    s7_fe  <= s6_fe;
    s8_fe  <= s7_fe;
    for (int i = 0; i < TAPS; i++) begin
      s2_bank[i] <= bank_next[i];
      s3_bank[i] <= s2_bank[i];
      s4_bank[i] <= s3_bank[i];
      s5_bank[i] <= s4_bank[i];
      s6_px[i]   <= rdata[s5_bank[i]];
    end
    for (int c = 0; c < CHANNELS; c++) begin
      for (int i = 0; i < TAPS; i++) begin
        prod[c][i] <= lane_en[i] ? lane_wt[i] * s6_px[i][c*CHAN_W +: CHAN_W] : '0;
      end
      for (int g = 0; g < GROUPS; g++) part[c][g] <= part_next[c][g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
    end else begin
      s1.valid <= req.valid;
      s2_valid <= s1.valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      s8_valid <= s7_valid;
    end
  end

  always_comb begin
    res_valid        = s8_valid;
    res.px.red       = round_sat(total[0]);
    res.px.green     = round_sat(total[1]);
    res.px.blue      = round_sat(total[2]);
    res.frame_end    = s8_fe;
  end

endmodule

@@ rtl/separable_gaussian_blur_rgb_unit.sv @@
// Top level of the separable Gaussian blur: config, stream control, output queue.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_write_en           cfg_index, cfg_data
//   in       in         in_valid / in_ready    command, in_red, in_green, in_blue
//   out      out        out_valid / out_ready  out_red, out_green, out_blue, frame_end
//
// One item per cycle while in_ready is high. After a pixel that ends a row, with
// a nonzero radius, the horizontal window replicates the last pixel past the
// right edge, during which in_ready is low. A result leaves through a 16-entry
// output queue; in_ready drops while 16 results are queued or in flight.
// rst is synchronous; the row store needs no clearing, so the block takes items
// once reset is released. Output stalls fill the queue until credit stops input.
module separable_gaussian_blur_rgb_unit import sgb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic [CHAN_W-1:0]    in_red,
  input  logic [CHAN_W-1:0]    in_green,
  input  logic [CHAN_W-1:0]    in_blue,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAN_W-1:0]    out_red,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_blue,
  output logic                 frame_end
);

  logic [DIM_W-1:0] image_width, image_height;
  logic [RAD_W-1:0] radius;
  logic [CFG_W-1:0] weights_low, weights_high;

  logic [DIM_W-1:0]  eff_w, eff_h;
  logic [PEND_W-1:0] lag;

  logic [COL_W-1:0]   in_col, in_col_next;
  logic [BANK_W-1:0]  in_bank, in_bank_next;
  logic               flushing, flushing_next;
  logic [RAD_W-1:0]   flush_left, flush_left_next;
  logic [DIM_W:0]     flush_col, flush_col_next;
  logic [BANK_W-1:0]  flush_bank, flush_bank_next;
  logic               flush_emit, flush_emit_next;
  logic [PEND_W-1:0]  pending, pending_next, pend_inc;
  logic [COL_W-1:0]   out_col, out_col_next;
  logic [ROW_W-1:0]   out_row, out_row_next;
  logic [BANK_W-1:0]  out_bank, out_bank_next;
  logic [FIFO_AW:0]   credit, credit_next;

  logic      in_fire, out_fire, eor, want, emit;
  hop_t      hop;
  row_wr_t   row_wr;
  emit_req_t req;
  logic      res_valid;
  result_t   res;

  result_t            fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_AW:0]   fcount;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(1);
      image_height <= DIM_W'(1);
      radius       <= '0;
      weights_low  <= CFG_W'(1 << FRAC_W);
      weights_high <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_RADIUS:       radius       <= cfg_data[RAD_W-1:0];
        REG_WEIGHTS_LOW:  weights_low  <= cfg_data;
        REG_WEIGHTS_HIGH: weights_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) eff_w = DIM_W'(1);
    else if (image_width > DIM_W'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
    else eff_w = image_width;
    if (image_height == '0) eff_h = DIM_W'(1);
    else if (image_height > DIM_W'(MAX_HEIGHT)) eff_h = DIM_W'(MAX_HEIGHT);
    else eff_h = image_height;
    lag = ({{(PEND_W-RAD_W){1'b0}}, radius} * {{(PEND_W-DIM_W){1'b0}}, eff_w})
        + {{(PEND_W-RAD_W){1'b0}}, radius};
  end

  assign out_fire = out_valid && out_ready;
  assign in_ready = !flushing && (credit < (FIFO_AW+1)'(FIFO_DEPTH));
  assign in_fire  = in_valid && in_ready;
  assign eor      = ({1'b0, in_col} + DIM_W'(1)) >= eff_w;
  assign pend_inc = pending + PEND_W'(1);
  assign want     = pend_inc > lag;

  always_comb begin
    in_col_next     = in_col;
    in_bank_next    = in_bank;
    flushing_next   = flushing;
    flush_left_next = flush_left;
    flush_col_next  = flush_col;
    flush_bank_next = flush_bank;
    flush_emit_next = flush_emit;
    pending_next    = pending;
    hop             = '0;
    emit            = 1'b0;
    if (flushing) begin
      // replicate the last pixel past the right edge
      hop.step        = 1'b1;
      hop.repeat_px   = 1'b1;
      hop.wr          = !flush_col[DIM_W];
      hop.col         = flush_col[COL_W-1:0];
      hop.bank        = flush_bank;
      flush_col_next  = flush_col + (DIM_W+1)'(1);
      flush_left_next = flush_left - RAD_W'(1);
      if (flush_left == RAD_W'(1)) begin
        flushing_next = 1'b0;
        emit          = flush_emit;
      end
    end else if (in_fire) begin
      if (cmd_t'(command) == CMD_PIXEL) begin
        hop.step     = 1'b1;
        hop.fill     = in_col == '0;
        hop.px       = {in_blue, in_green, in_red};
        hop.wr       = in_col >= COL_W'(radius);
        hop.col      = in_col - COL_W'(radius);
        hop.bank     = in_bank;
        pending_next = want ? pending : pend_inc;
        if (eor) begin
          in_col_next  = '0;
          in_bank_next = bank_add(in_bank, BANK_W'(1));
          if (radius != '0) begin
            flushing_next   = 1'b1;
            flush_left_next = radius;
            flush_col_next  = {1'b0, eff_w} - (DIM_W+1)'(radius);
            flush_bank_next = in_bank;
            flush_emit_next = want;
          end else begin
            emit = want;
          end
        end else begin
          in_col_next = in_col + COL_W'(1);
          emit        = want;
        end
      end else if (pending != '0) begin
        emit         = 1'b1;
        pending_next = pending - PEND_W'(1);
      end
    end
  end

  always_comb begin
    out_col_next  = out_col;
    out_row_next  = out_row;
    out_bank_next = out_bank;
    req.valid     = emit;
    req.col       = out_col;
    req.row       = out_row;
    req.bank      = out_bank;
    req.frame_end = (({1'b0, out_row} + DIM_W'(1)) >= eff_h)
                 && (({1'b0, out_col} + DIM_W'(1)) >= eff_w);
    if (emit) begin
      if (({1'b0, out_col} + DIM_W'(1)) >= eff_w) begin
        out_col_next  = '0;
        out_bank_next = bank_add(out_bank, BANK_W'(1));
        out_row_next  = (({1'b0, out_row} + DIM_W'(1)) >= eff_h) ? '0 : out_row + ROW_W'(1);
      end else begin
        out_col_next = out_col + COL_W'(1);
      end
    end
    credit_next = credit + (FIFO_AW+1)'(emit) - (FIFO_AW+1)'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col     <= '0;
      in_bank    <= '0;
      flushing   <= 1'b0;
      flush_left <= '0;
      flush_col  <= '0;
      flush_bank <= '0;
      flush_emit <= 1'b0;
      pending    <= '0;
      out_col    <= '0;
      out_row    <= '0;
      out_bank   <= '0;
      credit     <= '0;
    end else begin
      in_col     <= in_col_next;
      in_bank    <= in_bank_next;
      flushing   <= flushing_next;
      flush_left <= flush_left_next;
      flush_col  <= flush_col_next;
      flush_bank <= flush_bank_next;
      flush_emit <= flush_emit_next;
      pending    <= pending_next;
      out_col    <= out_col_next;
      out_row    <= out_row_next;
      out_bank   <= out_bank_next;
      credit     <= credit_next;
    end
  end

  sgb_hfilter u_hfilter (
    .clk         (clk),
    .rst         (rst),
    .radius      (radius),
    .weights_low (weights_low),
    .weights_high(weights_high),
    .hop         (hop),
    .row_wr      (row_wr)
  );

  sgb_vfilter u_vfilter (
    .clk         (clk),
    .rst         (rst),
    .radius      (radius),
    .height      (eff_h),
    .weights_low (weights_low),
    .weights_high(weights_high),
    .row_wr      (row_wr),
    .req         (req),
    .res_valid   (res_valid),
    .res         (res)
  );

  // output queue; credit keeps it from overflowing
  always_ff @(posedge clk) begin
    if (res_valid) fifo_mem[wptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      fcount <= '0;
    end else begin
      if (res_valid) wptr <= wptr + FIFO_AW'(1);
      if (out_fire) rptr <= rptr + FIFO_AW'(1);
      fcount <= fcount + (FIFO_AW+1)'(res_valid) - (FIFO_AW+1)'(out_fire);
    end
  end

  assign out_valid = fcount != '0;
  assign out_red   = fifo_mem[rptr].px.red;
  assign out_green = fifo_mem[rptr].px.green;
  assign out_blue  = fifo_mem[rptr].px.blue;
  assign frame_end = fifo_mem[rptr].frame_end;

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("more results in flight than queue entries");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    fcount <= credit)
    else $error("output queue holds more than its credit");

  a_row_end_flush: assert property (@(posedge clk) disable iff (rst)
    (in_fire && command == CMD_PIXEL && eor && radius != '0) |=> flushing)
    else $error("row end did not start edge replication");

endmodule
